// ===== rtl/three_point_touch_calibration_solve_top_assert.svh =====
// assertion macros for the touch calibration solver checker
`ifndef THREE_POINT_TOUCH_CALIBRATION_SOLVE_TOP_ASSERT_SVH
`define THREE_POINT_TOUCH_CALIBRATION_SOLVE_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tpc checker: implication violated");

// expression must never hold
`define TPC_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("tpc checker: forbidden condition seen");

`endif

// ===== rtl/tpc_pkg.sv =====
// shared types and constants for the touch calibration solver
package tpc_pkg;

    localparam int NLANE  = 6;
    localparam int GAIN_W = 32;
    localparam int OFFS_W = 48;

    localparam int LANE_XGX = 0;
    localparam int LANE_XGY = 1;
    localparam int LANE_XOF = 2;
    localparam int LANE_YGX = 3;
    localparam int LANE_YGY = 4;
    localparam int LANE_YOF = 5;

    typedef struct packed {
        logic             vld;
        logic             degen;
        logic [NLANE-1:0] neg;
    } t_ctl;

endpackage

// ===== rtl/three_point_touch_calibration_solve_top.sv =====
// three point touch calibration solver, top level
// Takes one calibration set per clock: busy stays low and start may be held
// high every cycle. Each set gives one result, strobed by o_done for a single
// cycle. Each set passes a six stage front end of multipliers and adders,
// then the divider, a chain of one cell per quotient bit solving all six
// coefficients side by side, then an output register. The receiver cannot
// stall; results must be taken in the cycle they appear. Coefficients are
// Cramer's rule quotients with FRAC_BITS fraction bits, truncated toward
// zero and saturated to their field; a zero determinant raises o_degenerate
// and zeroes every coefficient.
module three_point_touch_calibration_solve_top import tpc_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [COORD_BITS-1:0]    i_scr0_x,
    input  logic [COORD_BITS-1:0]    i_scr0_y,
    input  logic [COORD_BITS-1:0]    i_scr1_x,
    input  logic [COORD_BITS-1:0]    i_scr1_y,
    input  logic [COORD_BITS-1:0]    i_scr2_x,
    input  logic [COORD_BITS-1:0]    i_scr2_y,
    input  logic [COORD_BITS-1:0]    i_raw0_x,
    input  logic [COORD_BITS-1:0]    i_raw0_y,
    input  logic [COORD_BITS-1:0]    i_raw1_x,
    input  logic [COORD_BITS-1:0]    i_raw1_y,
    input  logic [COORD_BITS-1:0]    i_raw2_x,
    input  logic [COORD_BITS-1:0]    i_raw2_y,
    output logic                     o_done,
    output logic signed [GAIN_W-1:0] o_x_gain_from_x,
    output logic signed [GAIN_W-1:0] o_x_gain_from_y,
    output logic signed [OFFS_W-1:0] o_x_offset,
    output logic signed [GAIN_W-1:0] o_y_gain_from_x,
    output logic signed [GAIN_W-1:0] o_y_gain_from_y,
    output logic signed [OFFS_W-1:0] o_y_offset,
    output logic                     o_degenerate
);

    localparam int CW = COORD_BITS;
    localparam int DW = 2 * CW + 2;
    localparam int NW = 3 * CW + 4;
    localparam int NB = NW + FRAC_BITS;
    localparam int EW = ((NB > OFFS_W) ? NB : OFFS_W) + 1;

    logic [CW-1:0] w_sx [3], w_sy [3], w_tx [3], w_ty [3];
    logic [NW-1:0] w_mag [NLANE];

    t_ctl          w_ctl [NB+1];
    logic [DW-1:0] w_den [NB+1];
    logic [DW-1:0] w_rem [NB+1][NLANE];
    logic [NB-1:0] w_q   [NB+1][NLANE];

    logic [OFFS_W-1:0] w_res [NLANE];
    logic [OFFS_W-1:0] r_res [NLANE];
    logic              r_done, r_degen;

    assign busy = 1'b0;

    assign w_sx = '{i_scr0_x, i_scr1_x, i_scr2_x};
    assign w_sy = '{i_scr0_y, i_scr1_y, i_scr2_y};
    assign w_tx = '{i_raw0_x, i_raw1_x, i_raw2_x};
    assign w_ty = '{i_raw0_y, i_raw1_y, i_raw2_y};

    tpc_front #(.CW(CW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_sx    (w_sx),
        .i_sy    (w_sy),
        .i_tx    (w_tx),
        .i_ty    (w_ty),
        .o_ctl   (w_ctl[0]),
        .o_den   (w_den[0]),
        .o_mag   (w_mag)
    );

    always_comb begin
        for (int k = 0; k < NLANE; k++) begin
            w_rem[0][k] = '0;
            w_q[0][k]   = {w_mag[k], {FRAC_BITS{1'b0}}};
        end
    end

    for (genvar g = 0; g < NB; g++) begin : g_cell
        tpc_div_cell #(.DW(DW), .NB(NB)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_den   (w_den[g]),
            .i_rem   (w_rem[g]),
            .i_q     (w_q[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_den   (w_den[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_q     (w_q[g+1])
        );
    end

    for (genvar k = 0; k < NLANE; k++) begin : g_sat
        localparam int OW = (k == LANE_XOF || k == LANE_YOF) ? OFFS_W : GAIN_W;
        logic [EW-1:0] w_lim, w_qx, w_mg, w_sg;
        assign w_lim = (EW'(1) << (OW - 1)) - EW'(!w_ctl[NB].neg[k]);
        assign w_qx  = EW'(w_q[NB][k]);
        assign w_mg  = (w_qx > w_lim) ? w_lim : w_qx;
        assign w_sg  = w_ctl[NB].neg[k] ? -w_mg : w_mg;
        assign w_res[k] = w_ctl[NB].degen ? '0 : OFFS_W'(w_sg[OW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_ctl[NB].vld;
        end
        r_degen <= w_ctl[NB].degen;
        r_res   <= w_res;
    end

    assign o_done          = r_done;
    assign o_degenerate    = r_degen;
    assign o_x_gain_from_x = r_res[LANE_XGX][GAIN_W-1:0];
    assign o_x_gain_from_y = r_res[LANE_XGY][GAIN_W-1:0];
    assign o_x_offset      = r_res[LANE_XOF];
    assign o_y_gain_from_x = r_res[LANE_YGX][GAIN_W-1:0];
    assign o_y_gain_from_y = r_res[LANE_YGY][GAIN_W-1:0];
    assign o_y_offset      = r_res[LANE_YOF];

endmodule

// ===== rtl/tpc_div_cell.sv =====
// one restoring division step for all six lanes, registered
module tpc_div_cell import tpc_pkg::*; #(
    parameter int DW = 26,
    parameter int NB = 56
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ctl          i_ctl,
    input  logic [DW-1:0] i_den,
    input  logic [DW-1:0] i_rem [NLANE],
    input  logic [NB-1:0] i_q   [NLANE],
    output t_ctl          o_ctl,
    output logic [DW-1:0] o_den,
    output logic [DW-1:0] o_rem [NLANE],
    output logic [NB-1:0] o_q   [NLANE]
);

    logic [DW:0]   w_sh  [NLANE];
    logic [DW:0]   w_t   [NLANE];
    logic [DW-1:0] n_rem [NLANE];
    logic [NB-1:0] n_q   [NLANE];

    always_comb begin
        for (int k = 0; k < NLANE; k++) begin
            w_sh[k] = {i_rem[k], i_q[k][NB-1]};
            w_t[k]  = w_sh[k] - {1'b0, i_den};
            if (!w_t[k][DW]) begin
                n_rem[k] = w_t[k][DW-1:0];
                n_q[k]   = {i_q[k][NB-2:0], 1'b1};
            end else begin
                n_rem[k] = w_sh[k][DW-1:0];
                n_q[k]   = {i_q[k][NB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.vld <= 1'b0;
        end else begin
            o_ctl.vld <= i_ctl.vld;
        end
        o_ctl.degen <= i_ctl.degen;
        o_ctl.neg   <= i_ctl.neg;
        o_den       <= i_den;
        o_rem       <= n_rem;
        o_q         <= n_q;
    end

endmodule

// ===== rtl/tpc_front.sv =====
// determinant and numerator pipeline with sign and magnitude split
module tpc_front import tpc_pkg::*; #(
    parameter int CW = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [CW-1:0]     i_sx [3],
    input  logic [CW-1:0]     i_sy [3],
    input  logic [CW-1:0]     i_tx [3],
    input  logic [CW-1:0]     i_ty [3],
    output t_ctl              o_ctl,
    output logic [2*CW+1:0]   o_den,
    output logic [3*CW+3:0]   o_mag [NLANE]
);

    localparam int PW  = 2 * CW + 2;
    localparam int CCW = 2 * CW + 1;
    localparam int OPW = 3 * CW + 2;
    localparam int NW  = 3 * CW + 4;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    logic [CW-1:0] r1_sx [3], r1_sy [3], r1_tx [3], r1_ty [3];
    logic [CW-1:0] r2_sx [3], r2_sy [3];
    logic [CW-1:0] r3_sx [3], r3_sy [3];

    logic signed [CW:0] dx0, dx1, dy0, dy1, ex0, ex1, ey0, ey1;

    logic signed [PW-1:0]  r2_p [10];
    logic [2*CW-1:0]       r2_c [6];
    logic signed [PW-1:0]  r3_det;
    logic signed [PW-1:0]  r3_g [4];
    logic signed [CCW-1:0] r3_cc [3];
    logic signed [PW-1:0]  r4_det;
    logic signed [PW-1:0]  r4_g [4];
    logic signed [OPW-1:0] r4_ox [3], r4_oy [3];
    logic signed [PW-1:0]  r5_det;
    logic signed [NW-1:0]  r5_num [NLANE];

    assign dx0 = $signed({1'b0, r1_tx[0]}) - $signed({1'b0, r1_tx[2]});
    assign dx1 = $signed({1'b0, r1_tx[1]}) - $signed({1'b0, r1_tx[2]});
    assign dy0 = $signed({1'b0, r1_ty[0]}) - $signed({1'b0, r1_ty[2]});
    assign dy1 = $signed({1'b0, r1_ty[1]}) - $signed({1'b0, r1_ty[2]});
    assign ex0 = $signed({1'b0, r1_sx[0]}) - $signed({1'b0, r1_sx[2]});
    assign ex1 = $signed({1'b0, r1_sx[1]}) - $signed({1'b0, r1_sx[2]});
    assign ey0 = $signed({1'b0, r1_sy[0]}) - $signed({1'b0, r1_sy[2]});
    assign ey1 = $signed({1'b0, r1_sy[1]}) - $signed({1'b0, r1_sy[2]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            o_ctl.vld <= 1'b0;
        end else begin
            r_v1      <= i_vld;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_v5      <= r_v4;
            o_ctl.vld <= r_v5;
        end

        // input capture
        r1_sx <= i_sx;
        r1_sy <= i_sy;
        r1_tx <= i_tx;
        r1_ty <= i_ty;

        // first products
        r2_p[0] <= dx0 * dy1;
        r2_p[1] <= dx1 * dy0;
        r2_p[2] <= ex0 * dy1;
        r2_p[3] <= ex1 * dy0;
        r2_p[4] <= dx0 * ex1;
        r2_p[5] <= dx1 * ex0;
        r2_p[6] <= ey0 * dy1;
        r2_p[7] <= ey1 * dy0;
        r2_p[8] <= dx0 * ey1;
        r2_p[9] <= dx1 * ey0;
        r2_c[0] <= r1_tx[1] * r1_ty[2];
        r2_c[1] <= r1_tx[2] * r1_ty[1];
        r2_c[2] <= r1_tx[0] * r1_ty[2];
        r2_c[3] <= r1_tx[2] * r1_ty[0];
        r2_c[4] <= r1_tx[0] * r1_ty[1];
        r2_c[5] <= r1_tx[1] * r1_ty[0];
        r2_sx   <= r1_sx;
        r2_sy   <= r1_sy;

        // differences of products
        r3_det <= r2_p[0] - r2_p[1];
        for (int k = 0; k < 4; k++) begin
            r3_g[k] <= r2_p[2*k+2] - r2_p[2*k+3];
        end
        for (int k = 0; k < 3; k++) begin
            r3_cc[k] <= $signed({1'b0, r2_c[2*k]}) - $signed({1'b0, r2_c[2*k+1]});
        end
        r3_sx <= r2_sx;
        r3_sy <= r2_sy;

        // offset products
        r4_det <= r3_det;
        r4_g   <= r3_g;
        for (int k = 0; k < 3; k++) begin
            r4_ox[k] <= $signed({1'b0, r3_sx[k]}) * r3_cc[k];
            r4_oy[k] <= $signed({1'b0, r3_sy[k]}) * r3_cc[k];
        end

        // offset sums
        r5_det           <= r4_det;
        r5_num[LANE_XGX] <= NW'(r4_g[0]);
        r5_num[LANE_XGY] <= NW'(r4_g[1]);
        r5_num[LANE_YGX] <= NW'(r4_g[2]);
        r5_num[LANE_YGY] <= NW'(r4_g[3]);
        r5_num[LANE_XOF] <= NW'(r4_ox[0]) - NW'(r4_ox[1]) + NW'(r4_ox[2]);
        r5_num[LANE_YOF] <= NW'(r4_oy[0]) - NW'(r4_oy[1]) + NW'(r4_oy[2]);

        // sign and magnitude
        o_ctl.degen <= (r5_det == '0);
        o_den       <= r5_det[PW-1] ? PW'(-r5_det) : PW'(r5_det);
        for (int k = 0; k < NLANE; k++) begin
            o_ctl.neg[k] <= r5_num[k][NW-1] ^ r5_det[PW-1];
            o_mag[k]     <= r5_num[k][NW-1] ? NW'(-r5_num[k]) : NW'(r5_num[k]);
        end
    end

endmodule

// ===== rtl/tpc_checker.sv =====
// port level checks for the touch calibration solver, bound to the top level
`include "three_point_touch_calibration_solve_top_assert.svh"

module tpc_checker #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [COORD_BITS-1:0] i_raw0_x,
    input logic [COORD_BITS-1:0] i_raw0_y,
    input logic [COORD_BITS-1:0] i_raw1_x,
    input logic [COORD_BITS-1:0] i_raw1_y,
    input logic [COORD_BITS-1:0] i_raw2_x,
    input logic [COORD_BITS-1:0] i_raw2_y,
    input logic                  o_done,
    input logic [31:0]           o_x_gain_from_x,
    input logic [31:0]           o_x_gain_from_y,
    input logic [47:0]           o_x_offset,
    input logic [31:0]           o_y_gain_from_x,
    input logic [31:0]           o_y_gain_from_y,
    input logic [47:0]           o_y_offset,
    input logic                  o_degenerate
);

    localparam int LAT = 3 * COORD_BITS + 4 + FRAC_BITS + 7;

    logic w_same;
    logic w_coef_zero;

    assign w_same = (i_raw0_x == i_raw1_x) && (i_raw0_x == i_raw2_x)
                 && (i_raw0_y == i_raw1_y) && (i_raw0_y == i_raw2_y);

    assign w_coef_zero = (o_x_gain_from_x == '0) && (o_x_gain_from_y == '0)
                      && (o_x_offset == '0) && (o_y_gain_from_x == '0)
                      && (o_y_gain_from_y == '0) && (o_y_offset == '0);

    `TPC_ASSERT_NEVER(a_never_busy, busy)

    `TPC_ASSERT_IMP(a_done_follows_start, o_done, $past(start, LAT))

    `TPC_ASSERT_IMP(a_degen_zero, o_done && o_degenerate, w_coef_zero)

    `TPC_ASSERT_IMP(a_same_points_degen, o_done && $past(w_same, LAT), o_degenerate)

endmodule

bind three_point_touch_calibration_solve_top tpc_checker #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
) u_tpc_checker (.*);
